// File: rtl/core/mtse_pkg.sv
// ----------------------------------------------------------------------------
// mtse_pkg
// Shared types and constants of the multitouch slot event encoder.
// ----------------------------------------------------------------------------
package mtse_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [7:0] SLOT_LIMIT = 8'(NUM_SLOTS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int NUM_CODES = 7;

   // Input actions.
   localparam logic [1:0] ACT_DOWN  = 2'd0;
   localparam logic [1:0] ACT_MOVE  = 2'd1;
   localparam logic [1:0] ACT_UP    = 2'd2;

   // Event types.
   localparam logic [1:0] TYPE_ABS = 2'd0;
   localparam logic [1:0] TYPE_KEY = 2'd1;
   localparam logic [1:0] TYPE_SYN = 2'd2;

   // Event codes; each also names its bit in the per-command event mask.
   localparam logic [2:0] CODE_SLOT   = 3'd0;
   localparam logic [2:0] CODE_TRACK  = 3'd1;
   localparam logic [2:0] CODE_X      = 3'd2;
   localparam logic [2:0] CODE_Y      = 3'd3;
   localparam logic [2:0] CODE_PRESS  = 3'd4;
   localparam logic [2:0] CODE_TOUCH  = 3'd5;
   localparam logic [2:0] CODE_REPORT = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [15:0] FULL_SCALE = 16'hFFFF;
   localparam logic [31:0] TRACK_FREE = 32'hFFFF_FFFF;

   // One classified transaction, handed from the front end to the event sequencer.
   typedef struct packed {
      logic [7:0]  slot_id;
      logic        has_slot;
      logic        has_track;
      logic        track_free;
      logic        has_pos;
      logic        has_frame;
      logic [30:0] track_id;
      logic [31:0] prod_x;
      logic [31:0] prod_y;
      logic [15:0] pressure;
      logic        active;
   } cmd_type;

   // Queue handshake between the two halves.
   typedef struct packed {
      logic push;
   } q_wr_type;

   typedef struct packed {
      logic pop;
   } q_rd_type;

endpackage

// File: rtl/core/mtse_front.sv
// ----------------------------------------------------------------------------
// mtse_front
// Accepts slot reports, tracks slot occupancy and IDs, forms the scaling
// products and queues one command per transaction that causes events.
// ----------------------------------------------------------------------------
module mtse_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_slot_valid,
   input  logic [7:0]            req_slot_id,
   input  logic [1:0]            req_action,
   input  logic [15:0]           req_pos_x,
   input  logic [15:0]           req_pos_y,
   input  logic [15:0]           req_pressure,
   input  logic                  req_frame_end,
   input  logic                  q_full,
   output logic                  q_push,
   output mtse_pkg::cmd_type     q_cmd
);
   import mtse_pkg::*;

   logic                 enable_ff, enable_in;
   logic [15:0]          width_ff, width_in;
   logic [15:0]          height_ff, height_in;
   logic [NUM_SLOTS-1:0] busy_ff, busy_in;
   logic [30:0]          next_id_ff, next_id_in;

   logic              accept;
   logic              work;
   logic              slot_ok;
   logic              is_down;
   logic              is_move;
   logic              is_up;
   logic [SLOT_W-1:0] slot_idx;
   logic [15:0]       span_x;
   logic [15:0]       span_y;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign work      = accept && enable_ff;
   assign slot_ok   = req_slot_valid && (req_slot_id < SLOT_LIMIT);
   assign is_down   = (req_action == ACT_DOWN);
   assign is_move   = (req_action == ACT_MOVE);
   assign is_up     = (req_action == ACT_UP);
   assign slot_idx  = req_slot_id[SLOT_W-1:0];

   // A zero surface size scales like size one.
   assign span_x = (width_ff == 16'd0) ? 16'd0 : width_ff - 16'd1;
   assign span_y = (height_ff == 16'd0) ? 16'd0 : height_ff - 16'd1;

   always_comb begin
      enable_in = enable_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in = csr_wr_data[0];
            CSR_WIDTH:  width_in  = csr_wr_data;
            CSR_HEIGHT: height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      next_id_in = next_id_ff;
      if (work && slot_ok) begin
         if (is_down) begin
            busy_in[slot_idx] = 1'b1;
            next_id_in        = next_id_ff + 31'd1;
         end else if (is_up) begin
            busy_in[slot_idx] = 1'b0;
         end
      end
   end

   always_comb begin
      q_cmd.slot_id    = req_slot_id;
      q_cmd.has_slot   = slot_ok;
      q_cmd.has_track  = slot_ok && (is_down || is_up);
      q_cmd.track_free = is_up;
      q_cmd.has_pos    = slot_ok && (is_down || is_move);
      q_cmd.has_frame  = req_frame_end;
      q_cmd.track_id   = next_id_ff;
      q_cmd.prod_x     = 32'(req_pos_x) * 32'(span_x);
      q_cmd.prod_y     = 32'(req_pos_y) * 32'(span_y);
      q_cmd.pressure   = req_pressure;
      // Touch key reflects occupancy after this transaction.
      q_cmd.active     = |busy_in;
   end

   assign q_push = work && (slot_ok || req_frame_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         width_ff   <= 16'd1;
         height_ff  <= 16'd1;
         busy_ff    <= '0;
         next_id_ff <= '0;
      end else begin
         enable_ff  <= enable_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         busy_ff    <= busy_in;
         next_id_ff <= next_id_in;
      end
   end

endmodule

// File: rtl/core/mtse_queue.sv
// ----------------------------------------------------------------------------
// mtse_queue
// Short command FIFO that decouples the front end from the event sequencer.
// ----------------------------------------------------------------------------
module mtse_queue (
   input  logic                clock,
   input  logic                reset,
   input  mtse_pkg::q_wr_type  wr_ctl,
   input  mtse_pkg::cmd_type   wr_cmd,
   input  mtse_pkg::q_rd_type  rd_ctl,
   output logic                full,
   output logic                empty,
   output mtse_pkg::cmd_type   rd_cmd
);
   import mtse_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   localparam logic [QUEUE_AW:0]   DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW-1:0] LAST_PTR  = QUEUE_AW'(QUEUE_DEPTH - 1);

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = wr_ctl.push && !full;
   assign do_pop  = rd_ctl.pop && !empty;
   assign rd_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// File: rtl/core/mtse_back.sv
// ----------------------------------------------------------------------------
// mtse_back
// Event sequencer: walks the events of the head command, finishes the
// coordinate scaling and drives the registered result channel.
// ----------------------------------------------------------------------------
module mtse_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  mtse_pkg::cmd_type  q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_type,
   output logic [2:0]         rsp_event_code,
   output logic signed [31:0] rsp_event_value,
   output logic               rsp_last
);
   import mtse_pkg::*;

   logic [NUM_CODES-1:0] done_ff, done_in;
   logic                 valid_ff, valid_in;
   logic [1:0]           type_ff, type_in;
   logic [2:0]           code_ff, code_in;
   logic [31:0]          value_ff, value_in;
   logic                 last_ff, last_in;

   logic [NUM_CODES-1:0] mask;
   logic [NUM_CODES-1:0] remain;
   logic [NUM_CODES-1:0] sel;
   logic [2:0]           code;
   logic                 advance;
   logic                 emit;
   logic [15:0]          quot_x;
   logic [15:0]          quot_y;

   // Division by 65535: with p = hi*65536 + lo, p - 65535*hi = lo + hi,
   // which stays below twice the divisor, so one correction step suffices.
   function automatic logic [15:0] div_full_scale(input logic [31:0] prod);
      logic [16:0] rem;
      rem = {1'b0, prod[15:0]} + {1'b0, prod[31:16]};
      return prod[31:16] + ((rem >= {1'b0, FULL_SCALE}) ? 16'd1 : 16'd0);
   endfunction

   assign quot_x = div_full_scale(q_cmd.prod_x);
   assign quot_y = div_full_scale(q_cmd.prod_y);

   always_comb begin
      mask                    = '0;
      mask[CODE_SLOT]         = q_cmd.has_slot;
      mask[CODE_TRACK]        = q_cmd.has_track;
      mask[CODE_X]            = q_cmd.has_pos;
      mask[CODE_Y]            = q_cmd.has_pos;
      mask[CODE_PRESS]        = q_cmd.has_pos;
      mask[CODE_TOUCH]        = q_cmd.has_frame;
      mask[CODE_REPORT]       = q_cmd.has_frame;
   end

   assign remain  = mask & ~done_ff;
   assign sel     = remain & (~remain + 1'b1);
   assign advance = !valid_ff || rsp_ready;
   assign emit    = advance && !q_empty;

   always_comb begin
      code = CODE_SLOT;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (sel[i]) begin
            code = 3'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      type_in  = type_ff;
      code_in  = code_ff;
      value_in = value_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      q_pop    = 1'b0;
      if (advance) begin
         valid_in = emit;
      end
      if (emit) begin
         code_in = code;
         last_in = (remain == sel);
         unique case (code)
            CODE_SLOT: begin
               type_in  = TYPE_ABS;
               value_in = {24'd0, q_cmd.slot_id};
            end
            CODE_TRACK: begin
               type_in  = TYPE_ABS;
               value_in = q_cmd.track_free ? TRACK_FREE : {1'b0, q_cmd.track_id};
            end
            CODE_X: begin
               type_in  = TYPE_ABS;
               value_in = {16'd0, quot_x};
            end
            CODE_Y: begin
               type_in  = TYPE_ABS;
               value_in = {16'd0, quot_y};
            end
            CODE_PRESS: begin
               type_in  = TYPE_ABS;
               value_in = {16'd0, q_cmd.pressure};
            end
            CODE_TOUCH: begin
               type_in  = TYPE_KEY;
               value_in = {31'd0, q_cmd.active};
            end
            CODE_REPORT: begin
               type_in  = TYPE_SYN;
               value_in = '0;
            end
            default: begin
               type_in  = TYPE_ABS;
               value_in = '0;
            end
         endcase
         if (remain == sel) begin
            done_in = '0;
            q_pop   = 1'b1;
         end else begin
            done_in = done_ff | sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      code_ff  <= code_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_type  = type_ff;
   assign rsp_event_code  = code_ff;
   assign rsp_event_value = signed'(value_ff);
   assign rsp_last        = last_ff;

endmodule

// File: rtl/core/multitouch_slot_event_encoder_top.sv
// The first event of a transaction passes through the command queue and the output register.
// Throughput: one event per cycle from the single output register while rsp_ready
// is held high; a slot report that is queued causes 1 to 7 events, and a two-entry queue
// lets new reports enter while earlier events drain.
// Reset (synchronous): all slots free, tracking ID counter 0, block disabled,
// surface size 1 by 1, queue and output empty.
// ----------------------------------------------------------------------------
// multitouch_slot_event_encoder_top
// Turns touch-slot reports into multitouch type B slot, axis, key and sync events.
// ----------------------------------------------------------------------------
module multitouch_slot_event_encoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_slot_valid,
   input  logic [7:0]         req_slot_id,
   input  logic [1:0]         req_action,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [15:0]        req_pressure,
   input  logic               req_frame_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_type,
   output logic [2:0]         rsp_event_code,
   output logic signed [31:0] rsp_event_value,
   output logic               rsp_last
);
   import mtse_pkg::*;

   cmd_type  wr_cmd;
   cmd_type  rd_cmd;
   q_wr_type wr_ctl;
   q_rd_type rd_ctl;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   assign wr_ctl.push  = push;
   assign rd_ctl.pop   = pop;

   mtse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_slot_valid (req_slot_valid),
      .req_slot_id    (req_slot_id),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pressure   (req_pressure),
      .req_frame_end  (req_frame_end),
      .q_full         (full),
      .q_push         (push),
      .q_cmd          (wr_cmd)
   );

   mtse_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_ctl (wr_ctl),
      .wr_cmd (wr_cmd),
      .rd_ctl (rd_ctl),
      .full   (full),
      .empty  (empty),
      .rd_cmd (rd_cmd)
   );

   mtse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (empty),
      .q_cmd           (rd_cmd),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_type  (rsp_event_type),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/core/mtse_checker.sv
// ----------------------------------------------------------------------------
// mtse_checker
// Port-level checks of the event stream, bound to the top level.
// ----------------------------------------------------------------------------
module mtse_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_event_type,
   input logic [2:0]         rsp_event_code,
   input logic signed [31:0] rsp_event_value,
   input logic               rsp_last
);
   import mtse_pkg::*;

   // A stalled event holds its code, value and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_event_value) && $stable(rsp_last))
      else $error("stalled event changed");

   // The sync report always closes its transaction and carries zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == CODE_REPORT |->
         rsp_last && rsp_event_type == TYPE_SYN && rsp_event_value == 0)
      else $error("malformed sync report");

   // The touch key is never the last event; a sync report follows it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == CODE_TOUCH |->
         !rsp_last && rsp_event_type == TYPE_KEY)
      else $error("touch key ends a transaction");

   // Slot selects only name slots below the limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == CODE_SLOT |->
         rsp_event_value >= 0 && rsp_event_value < NUM_SLOTS)
      else $error("slot select out of range");

endmodule

bind multitouch_slot_event_encoder_top mtse_checker u_mtse_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_type  (rsp_event_type),
   .rsp_event_code  (rsp_event_code),
   .rsp_event_value (rsp_event_value),
   .rsp_last        (rsp_last)
);
